>>> src/ppd_pkg.sv
// Package for the periodic point distance block: widths, latency, payload
// structs and register index codes. Depends on nothing.
`default_nettype none

package ppd_pkg;

   localparam int COORD_FRAC_BITS_DEF = 20;

   localparam int PT_W   = 32;   // coordinate and result width
   localparam int D_W    = 34;   // clamped delta component, signed
   localparam int NUM_W  = 35;   // wrap quotient bits (magnitude of 2*d + den)
   localparam int WDEN_W = 32;   // wrap divisor, twice the box diagonal
   localparam int N_W    = 33;   // clamped wrap count, signed
   localparam int S_W    = 68;   // sum of squares
   localparam int ROOT_W = S_W / 2;
   localparam int RND_W  = ROOT_W + 1;
   localparam int DQ_W   = 31;   // derivative quotient bits

   // Register count from an accepted request to its response strobe.
   localparam int LATENCY = 2 + 3 * (NUM_W + 4) + 4 + ROOT_W + 1 + DQ_W + 1;

   typedef enum logic [2:0] {
      CSR_PERIODIC_ON = 3'd0,
      CSR_BOX_A_X     = 3'd1,
      CSR_BOX_B_X     = 3'd2,
      CSR_BOX_B_Y     = 3'd3,
      CSR_BOX_C_X     = 3'd4,
      CSR_BOX_C_Y     = 3'd5,
      CSR_BOX_C_Z     = 3'd6
   } ppd_csr_type;

   typedef struct packed {
      logic               func;
      logic [2:0]         deriv_index;
      logic signed [31:0] point_a_x;
      logic signed [31:0] point_a_y;
      logic signed [31:0] point_a_z;
      logic signed [31:0] point_b_x;
      logic signed [31:0] point_b_y;
      logic signed [31:0] point_b_z;
   } ppd_req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               saturated;
   } ppd_rsp_type;

   typedef logic signed [D_W-1:0] ppd_delta_type;

   // Work item carried down the wrap and distance pipeline.
   typedef struct packed {
      logic                func;
      logic [2:0]          deriv_index;
      logic                sat;
      ppd_delta_type [2:0] d;
   } ppd_item_type;

endpackage

`default_nettype wire

>>> src/ppd_div.sv
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband that travels alongside. Depends on ppd_pkg for default widths.
`default_nettype none

module ppd_div
   import ppd_pkg::*;
#(
   parameter int NUM_W  = DQ_W,
   parameter int DEN_W  = RND_W,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_rem,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [NUM_W-1:0]       out_quo,
   output logic [DEN_W-1:0]       out_rem,
   output logic [SIDE_W-1:0]      out_side
);

   logic              valid_ff [NUM_W];
   logic [NUM_W-1:0]  num_ff   [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic              pv;
      logic [NUM_W-1:0]  pn;
      logic [DEN_W-1:0]  pr;
      logic [DEN_W-1:0]  pd;
      logic [SIDE_W-1:0] ps;
      logic [DEN_W:0]    trial;
      logic              ge;

      if (i == 0) begin : g_first
         assign pv = in_valid;
         assign pn = in_num;
         assign pr = in_rem;
         assign pd = in_den;
         assign ps = in_side;
      end else begin : g_next
         assign pv = valid_ff[i-1];
         assign pn = num_ff[i-1];
         assign pr = rem_ff[i-1];
         assign pd = den_ff[i-1];
         assign ps = side_ff[i-1];
      end

      // The numerator shifts out at the top while quotient bits enter below.
      assign trial = {pr, pn[NUM_W-1]};
      assign ge    = (trial >= {1'b0, pd});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= pv;
         end
         num_ff[i]  <= {pn[NUM_W-2:0], ge};
         rem_ff[i]  <= ge ? DEN_W'(trial - {1'b0, pd}) : DEN_W'(trial);
         den_ff[i]  <= pd;
         side_ff[i] <= ps;
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = num_ff[NUM_W-1];
   assign out_rem   = rem_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

`default_nettype wire

>>> src/ppd_sqrt.sv
// Pipelined integer square root, one root bit per register stage, giving
// root and remainder with a sideband. Depends on ppd_pkg for default widths.
`default_nettype none

module ppd_sqrt
   import ppd_pkg::*;
#(
   parameter int RAD_W  = S_W,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [RAD_W-1:0]  in_rad,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [RAD_W/2-1:0]     out_root,
   output logic [RAD_W/2+1:0]     out_rem,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int RT_W = RAD_W / 2;
   localparam int RM_W = RT_W + 2;

   logic              valid_ff [RT_W];
   logic [RAD_W-1:0]  rad_ff   [RT_W];
   logic [RT_W-1:0]   root_ff  [RT_W];
   logic [RM_W-1:0]   rem_ff   [RT_W];
   logic [SIDE_W-1:0] side_ff  [RT_W];

   for (genvar i = 0; i < RT_W; i++) begin : g_stage
      logic              pv;
      logic [RAD_W-1:0]  prad;
      logic [RT_W-1:0]   proot;
      logic [RM_W-1:0]   prem;
      logic [SIDE_W-1:0] ps;
      logic [RM_W+1:0]   t;
      logic [RM_W+1:0]   trial;
      logic              ge;

      if (i == 0) begin : g_first
         assign pv    = in_valid;
         assign prad  = in_rad;
         assign proot = '0;
         assign prem  = '0;
         assign ps    = in_side;
      end else begin : g_next
         assign pv    = valid_ff[i-1];
         assign prad  = rad_ff[i-1];
         assign proot = root_ff[i-1];
         assign prem  = rem_ff[i-1];
         assign ps    = side_ff[i-1];
      end

      assign t     = {prem, prad[RAD_W-1 -: 2]};
      assign trial = (RM_W+2)'({proot, 2'b01});
      assign ge    = (t >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= pv;
         end
         rad_ff[i]  <= {prad[RAD_W-3:0], 2'b00};
         root_ff[i] <= {proot[RT_W-2:0], ge};
         rem_ff[i]  <= ge ? RM_W'(t - trial) : RM_W'(t);
         side_ff[i] <= ps;
      end
   end

   assign out_valid = valid_ff[RT_W-1];
   assign out_root  = root_ff[RT_W-1];
   assign out_rem   = rem_ff[RT_W-1];
   assign out_side  = side_ff[RT_W-1];

endmodule

`default_nettype wire

>>> src/periodic_point_distance.sv
// Top level of the periodic point distance block: wrap pipeline, squares,
// square root and derivative divide. Depends on ppd_pkg, ppd_div, ppd_sqrt.
//
// The block takes one point pair per clock cycle and returns one response
// per pair, in order. The latency is set by the three minimum-image wrap
// steps, each with a 35-stage wrap-count divider, by the 34-stage square
// root and by the 31-stage derivative divider. busy is always low, and
// rsp_valid marks each response for exactly one cycle; the receiver must
// take it then. Box registers are written through the csr_ port; the user
// must write them only while no transaction is in flight, as the block
// itself does not enforce it. They are read directly by the wrap steps.
`default_nettype none

module periodic_point_distance
   import ppd_pkg::*;
#(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire ppd_req_type req_data,
   output logic             rsp_valid,
   output ppd_rsp_type      rsp_data,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);

   localparam logic [30:0] BOX_ONE = 31'(64'd1 << COORD_FRAC_BITS);

   // Configuration registers.
   logic               periodic_on_ff;
   logic [30:0]        box_a_x_ff;
   logic signed [31:0] box_b_x_ff;
   logic [30:0]        box_b_y_ff;
   logic signed [31:0] box_c_x_ff;
   logic signed [31:0] box_c_y_ff;
   logic [30:0]        box_c_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         periodic_on_ff <= 1'b0;
         box_a_x_ff     <= BOX_ONE;
         box_b_x_ff     <= '0;
         box_b_y_ff     <= BOX_ONE;
         box_c_x_ff     <= '0;
         box_c_y_ff     <= '0;
         box_c_z_ff     <= BOX_ONE;
      end else if (csr_write_enable) begin
         unique case (ppd_csr_type'(csr_index))
            CSR_PERIODIC_ON: periodic_on_ff <= csr_write_data[0];
            CSR_BOX_A_X:     box_a_x_ff     <= csr_write_data[30:0];
            CSR_BOX_B_X:     box_b_x_ff     <= csr_write_data;
            CSR_BOX_B_Y:     box_b_y_ff     <= csr_write_data[30:0];
            CSR_BOX_C_X:     box_c_x_ff     <= csr_write_data;
            CSR_BOX_C_Y:     box_c_y_ff     <= csr_write_data;
            CSR_BOX_C_Z:     box_c_z_ff     <= csr_write_data[30:0];
            default: begin
            end
         endcase
      end
   end

   // The pipeline never stalls, so a request is taken in every cycle.
   assign busy = 1'b0;

   // Request register.
   logic        in_valid_ff;
   ppd_req_type in_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      in_req_ff <= req_data;
   end

   // Raw difference A - B, 33 significant bits sign-extended to the delta width.
   logic         dl_valid_ff;
   ppd_item_type dl_item_ff;
   ppd_item_type dl_item_in;

   always_comb begin
      dl_item_in.func        = in_req_ff.func;
      dl_item_in.deriv_index = in_req_ff.deriv_index;
      dl_item_in.sat         = 1'b0;
      dl_item_in.d[0] = D_W'(in_req_ff.point_a_x) - D_W'(in_req_ff.point_b_x);
      dl_item_in.d[1] = D_W'(in_req_ff.point_a_y) - D_W'(in_req_ff.point_b_y);
      dl_item_in.d[2] = D_W'(in_req_ff.point_a_z) - D_W'(in_req_ff.point_b_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_valid_ff <= 1'b0;
      end else begin
         dl_valid_ff <= in_valid_ff;
      end
      dl_item_ff <= dl_item_in;
   end

   // Minimum-image wrap: step 0 removes c, step 1 removes b, step 2 removes a.
   // Each step computes n = floor((2d + den) / (2 den)) for its axis,
   // clamps n, multiplies each box component by n and subtracts with a clamp.
   logic         w_valid [4];
   ppd_item_type w_item  [4];

   assign w_valid[0] = dl_valid_ff;
   assign w_item[0]  = dl_item_ff;

   localparam int SIDE_W = $bits(ppd_item_type) + 1;
   localparam logic signed [64:0] DMAX = 65'sd8589934591;
   localparam logic signed [64:0] DMIN = -65'sd8589934592;
   localparam logic [NUM_W:0]     NLIM = (NUM_W+1)'(64'd1 << (N_W - 2));

   for (genvar s = 0; s < 3; s++) begin : g_wrap
      localparam int AXIS = 2 - s;

      logic [30:0]        den;
      logic signed [31:0] vec [3];

      if (s == 0) begin : g_box_c
         assign den    = box_c_z_ff;
         assign vec[0] = box_c_x_ff;
         assign vec[1] = box_c_y_ff;
         assign vec[2] = $signed({1'b0, box_c_z_ff});
      end else if (s == 1) begin : g_box_b
         assign den    = box_b_y_ff;
         assign vec[0] = box_b_x_ff;
         assign vec[1] = $signed({1'b0, box_b_y_ff});
         assign vec[2] = '0;
      end else begin : g_box_a
         assign den    = box_a_x_ff;
         assign vec[0] = $signed({1'b0, box_a_x_ff});
         assign vec[1] = '0;
         assign vec[2] = '0;
      end

      // Numerator 2d + den as sign and magnitude for the unsigned divider.
      logic               pr_valid_ff;
      ppd_item_type       pr_item_ff;
      logic               pr_neg_ff;
      logic [NUM_W-1:0]   pr_mag_ff;
      logic signed [D_W+1:0] num;

      assign num = $signed({w_item[s].d[AXIS][D_W-1], w_item[s].d[AXIS], 1'b0})
                 + $signed({5'b00000, den});

      always_ff @(posedge clock) begin
         if (reset) begin
            pr_valid_ff <= 1'b0;
         end else begin
            pr_valid_ff <= w_valid[s];
         end
         pr_item_ff <= w_item[s];
         pr_neg_ff  <= num[D_W+1];
         pr_mag_ff  <= num[D_W+1] ? NUM_W'(-num) : NUM_W'(num);
      end

      logic               dv_valid;
      logic [NUM_W-1:0]   dv_quo;
      logic [WDEN_W-1:0]  dv_rem;
      logic [SIDE_W-1:0]  dv_side;

      ppd_div #(
         .NUM_W  (NUM_W),
         .DEN_W  (WDEN_W),
         .SIDE_W (SIDE_W)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pr_valid_ff),
         .in_num    (pr_mag_ff),
         .in_rem    ('0),
         .in_den    ({den, 1'b0}),
         .in_side   ({pr_neg_ff, pr_item_ff}),
         .out_valid (dv_valid),
         .out_quo   (dv_quo),
         .out_rem   (dv_rem),
         .out_side  (dv_side)
      );

      // Floor correction for a negative numerator, clamp, or skip the step
      // when wrapping is off or the diagonal is zero.
      logic                  fx_valid_ff;
      ppd_item_type          fx_item_ff;
      ppd_item_type          fx_item_in;
      logic signed [N_W-1:0] fx_n_ff;
      logic signed [N_W-1:0] fx_n_in;
      logic                  dv_neg;
      logic [NUM_W:0]        qmag;

      assign dv_neg = dv_side[SIDE_W-1];
      assign qmag   = {1'b0, dv_quo} + (NUM_W+1)'(dv_neg && (dv_rem != '0));

      always_comb begin
         fx_item_in = dv_side[SIDE_W-2:0];
         if (!periodic_on_ff || (den == '0)) begin
            fx_n_in = '0;
         end else if (qmag > NLIM) begin
            fx_item_in.sat = 1'b1;
            fx_n_in = dv_neg ? -N_W'(NLIM) : N_W'(NLIM);
         end else begin
            fx_n_in = dv_neg ? -N_W'(qmag) : N_W'(qmag);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            fx_valid_ff <= 1'b0;
         end else begin
            fx_valid_ff <= dv_valid;
         end
         fx_item_ff <= fx_item_in;
         fx_n_ff    <= fx_n_in;
      end

      // Box component times wrap count.
      logic               mu_valid_ff;
      ppd_item_type       mu_item_ff;
      logic signed [63:0] mu_p_ff [3];

      for (genvar j = 0; j < 3; j++) begin : g_mul
         logic signed [64:0] prod;
         assign prod = vec[j] * fx_n_ff;
         always_ff @(posedge clock) begin
            mu_p_ff[j] <= prod[63:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            mu_valid_ff <= 1'b0;
         end else begin
            mu_valid_ff <= fx_valid_ff;
         end
         mu_item_ff <= fx_item_ff;
      end

      // Subtract and clamp every component.
      logic         sb_valid_ff;
      ppd_item_type sb_item_ff;
      ppd_item_type sb_item_in;

      always_comb begin
         logic signed [64:0] diff;
         sb_item_in = mu_item_ff;
         for (int j = 0; j < 3; j++) begin
            diff = 65'(mu_item_ff.d[j]) - 65'(mu_p_ff[j]);
            if (diff > DMAX) begin
               sb_item_in.sat  = 1'b1;
               sb_item_in.d[j] = D_W'(DMAX);
            end else if (diff < DMIN) begin
               sb_item_in.sat  = 1'b1;
               sb_item_in.d[j] = D_W'(DMIN);
            end else begin
               sb_item_in.d[j] = D_W'(diff);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sb_valid_ff <= 1'b0;
         end else begin
            sb_valid_ff <= mu_valid_ff;
         end
         sb_item_ff <= sb_item_in;
      end

      assign w_valid[s+1] = sb_valid_ff;
      assign w_item[s+1]  = sb_item_ff;
   end

   // Magnitudes of the wrapped delta.
   logic           ab_valid_ff;
   ppd_item_type   ab_item_ff;
   logic [D_W-1:0] ab_mag_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         ab_valid_ff <= 1'b0;
      end else begin
         ab_valid_ff <= w_valid[3];
      end
      ab_item_ff <= w_item[3];
      for (int j = 0; j < 3; j++) begin
         ab_mag_ff[j] <= w_item[3].d[j][D_W-1] ? D_W'(-w_item[3].d[j])
                                                : D_W'(w_item[3].d[j]);
      end
   end

   // Squares from 17-bit halves: high*high, high*low and low*low.
   localparam int H_W = D_W / 2;

   logic           pp_valid_ff;
   ppd_item_type   pp_item_ff;
   logic [2*H_W-1:0] pp_hh_ff [3];
   logic [2*H_W-1:0] pp_hl_ff [3];
   logic [2*H_W-1:0] pp_ll_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff <= 1'b0;
      end else begin
         pp_valid_ff <= ab_valid_ff;
      end
      pp_item_ff <= ab_item_ff;
      for (int j = 0; j < 3; j++) begin
         pp_hh_ff[j] <= ab_mag_ff[j][D_W-1:H_W] * ab_mag_ff[j][D_W-1:H_W];
         pp_hl_ff[j] <= ab_mag_ff[j][D_W-1:H_W] * ab_mag_ff[j][H_W-1:0];
         pp_ll_ff[j] <= ab_mag_ff[j][H_W-1:0] * ab_mag_ff[j][H_W-1:0];
      end
   end

   logic         sq_valid_ff;
   ppd_item_type sq_item_ff;
   logic [S_W-1:0] sq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= pp_valid_ff;
      end
      sq_item_ff <= pp_item_ff;
      for (int j = 0; j < 3; j++) begin
         sq_ff[j] <= (S_W'(pp_hh_ff[j]) << (2 * H_W))
                   + (S_W'(pp_hl_ff[j]) << (H_W + 1))
                   + S_W'(pp_ll_ff[j]);
      end
   end

   logic           su_valid_ff;
   ppd_item_type   su_item_ff;
   logic [S_W-1:0] su_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         su_valid_ff <= 1'b0;
      end else begin
         su_valid_ff <= sq_valid_ff;
      end
      su_item_ff <= sq_item_ff;
      su_sum_ff  <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   // Square root of the exact sum of squares.
   logic              rt_valid;
   logic [ROOT_W-1:0] rt_root;
   logic [ROOT_W+1:0] rt_rem;
   ppd_item_type      rt_item;

   ppd_sqrt #(
      .RAD_W  (S_W),
      .SIDE_W ($bits(ppd_item_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (su_valid_ff),
      .in_rad    (su_sum_ff),
      .in_side   (su_item_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_rem   (rt_rem),
      .out_side  (rt_item)
   );

   // Round the root to nearest, form the distance result and set up the
   // derivative divide for the chosen coordinate.
   logic             rd_valid_ff;
   logic             rd_func_ff;
   logic             rd_sat_ff;
   logic [31:0]      rd_dist_ff;
   logic             rd_neg_ff;
   logic             rd_zero_ff;
   logic [RND_W-1:0] rd_r_ff;
   logic [RND_W-1:0] rd_mag_ff;

   logic [RND_W-1:0]  r_rnd;
   logic              dist_sat;
   ppd_delta_type     dk;
   logic              from_b;
   logic              bad_index;

   assign r_rnd    = RND_W'(rt_root) + RND_W'(rt_rem > (ROOT_W+2)'(rt_root));
   assign dist_sat = (r_rnd > RND_W'(32'h7FFF_FFFF));

   always_comb begin
      dk        = rt_item.d[0];
      from_b    = 1'b0;
      bad_index = 1'b0;
      case (rt_item.deriv_index) inside
         3'd0:    dk = rt_item.d[0];
         3'd1:    dk = rt_item.d[1];
         3'd2:    dk = rt_item.d[2];
         3'd3: begin
            dk     = rt_item.d[0];
            from_b = 1'b1;
         end
         3'd4: begin
            dk     = rt_item.d[1];
            from_b = 1'b1;
         end
         3'd5: begin
            dk     = rt_item.d[2];
            from_b = 1'b1;
         end
         default: bad_index = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rt_valid;
      end
      rd_func_ff <= rt_item.func;
      rd_sat_ff  <= rt_item.sat | (~rt_item.func & dist_sat);
      rd_dist_ff <= dist_sat ? 32'h7FFF_FFFF : r_rnd[31:0];
      rd_neg_ff  <= dk[D_W-1] ^ from_b;
      rd_zero_ff <= bad_index | (r_rnd == '0);
      rd_r_ff    <= r_rnd;
      rd_mag_ff  <= dk[D_W-1] ? RND_W'(-dk) : RND_W'(dk);
   end

   // |delta_k| * 2^31 / r, one bit per stage; the coordinate never exceeds r.
   localparam int DSIDE_W = 36;

   logic               dq_valid;
   logic [DQ_W-1:0]    dq_quo;
   logic [RND_W-1:0]   dq_rem;
   logic [DSIDE_W-1:0] dq_side;

   ppd_div #(
      .NUM_W  (DQ_W),
      .DEN_W  (RND_W),
      .SIDE_W (DSIDE_W)
   ) u_deriv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .in_num    ('0),
      .in_rem    (rd_mag_ff),
      .in_den    (rd_r_ff),
      .in_side   ({rd_func_ff, rd_sat_ff, rd_dist_ff, rd_neg_ff, rd_zero_ff}),
      .out_valid (dq_valid),
      .out_quo   (dq_quo),
      .out_rem   (dq_rem),
      .out_side  (dq_side)
   );

   // The remainder of the derivative divide is not needed.
   logic dq_rem_unused;
   assign dq_rem_unused = ^dq_rem;

   // Response register: round the half-step quotient and apply the sign.
   logic        out_valid_ff;
   ppd_rsp_type out_rsp_ff;
   ppd_rsp_type out_rsp_in;
   logic [31:0] q_half;

   assign q_half = (32'(dq_quo) + 32'd1) >> 1;

   always_comb begin
      out_rsp_in.saturated = dq_side[34];
      if (!dq_side[35]) begin
         out_rsp_in.result_value = dq_side[33:2];
      end else if (dq_side[0]) begin
         out_rsp_in.result_value = '0;
      end else begin
         out_rsp_in.result_value = dq_side[1] ? -q_half : q_half;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dq_valid;
      end
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

endmodule

`default_nettype wire

>>> src/ppd_checker.sv
// Port-level checker for periodic_point_distance and its bind statement.
// Depends on ppd_pkg for the fixed latency and payload types.
`default_nettype none

module ppd_checker
   import ppd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire ppd_req_type req_data,
   input wire logic        rsp_valid,
   input wire ppd_rsp_type rsp_data
);

   // Every response comes a fixed number of cycles after its request.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start & ~busy, LATENCY))
      else $error("response without a request LATENCY cycles earlier");

   // A distance response is never negative.
   a_dist_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(req_data.func, LATENCY)) |-> !rsp_data.result_value[31])
      else $error("negative distance");

   // A derivative never exceeds one in magnitude.
   a_deriv_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_data.func, LATENCY)) |->
      (rsp_data.result_value <= 32'sh4000_0000 &&
       rsp_data.result_value >= -32'sh4000_0000))
      else $error("derivative out of range");

   // A bad coordinate index gives a zero derivative.
   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_data.func, LATENCY) &&
       ($past(req_data.deriv_index, LATENCY) == 3'd6 ||
        $past(req_data.deriv_index, LATENCY) == 3'd7)) |->
      (rsp_data.result_value == 32'sd0))
      else $error("nonzero derivative for a bad index");

endmodule

bind periodic_point_distance ppd_checker u_ppd_checker (.*);

`default_nettype wire
